>>> rtl/c5bm_pkg.sv
`timescale 1ns / 1ps
package c5bm_pkg;

	localparam int KSIZE       = 5;
	localparam int TAPS        = KSIZE * KSIZE;
	localparam int POOL_SIZE   = 2;
	localparam int MIN_SIZE    = 6;
	localparam int MAX_HEIGHT  = 1024;
	localparam int FRAC_BITS   = 8;

	localparam int SAMPLE_W    = 16;
	localparam int SLOT_W      = 5;
	localparam int IW_W        = 6;
	localparam int IH_W        = 11;
	localparam int VAL_W       = 27;
	localparam int ROW_W       = 10;
	localparam int COL_W       = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int PROD_W      = 2 * SAMPLE_W;
	localparam int SC_W        = PROD_W - FRAC_BITS;
	localparam int PART_W      = SC_W + 3;
	localparam int SUM_W       = PART_W + 3;

	localparam int PIPE_STAGES = 5;
	localparam int QDEPTH      = 8;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic ACT_PIXEL = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH,
		CFG_IMAGE_HEIGHT,
		CFG_BIAS_VALUE,
		CFG_POOL_ENABLE
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_DIRECT,
		OP_POOL_INIT,
		OP_POOL_MAX,
		OP_POOL_EMIT
	} op_t;

	typedef struct packed {
		logic [IW_W-1:0]     image_width;
		logic [IH_W-1:0]     image_height;
		logic [SAMPLE_W-1:0] bias_value;
		logic                pool_enable;
	} cfg_t;

	typedef struct packed {
		logic             pixel;
		logic             push;
		op_t              op;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             done;
	} meta_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		op_t              op;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             done;
	} job_t;

endpackage

>>> rtl/c5bm_ram.sv
`timescale 1ns / 1ps
module c5bm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/c5bm_front.sv
`timescale 1ns / 1ps
module c5bm_front #(
	parameter int MAX_WIDTH = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  c5bm_pkg::cfg_t                         cfg,
	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  logic                                   action,
	input  logic [c5bm_pkg::SLOT_W-1:0]            weight_slot,
	input  logic signed [c5bm_pkg::SAMPLE_W-1:0]   sample_value,
	input  logic [c5bm_pkg::QCNT_W-1:0]            q_count,
	output logic                                   push,
	output c5bm_pkg::job_t                         push_job
);
	import c5bm_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int LW = (KSIZE - 1) * SAMPLE_W;

	logic                 accept;
	logic [IW_W-1:0]      w;
	logic [IH_W-1:0]      h;
	logic [IW_W-1:0]      col_q;
	logic [ROW_W-1:0]     row_q;
	logic [IW_W-1:0]      c_cur;
	logic [IW_W-1:0]      c_nx;
	logic [IH_W-1:0]      r_pre;
	logic [IH_W-1:0]      r_wide;
	logic [ROW_W-1:0]     r_cur;
	logic [ROW_W-1:0]     r_nx;
	logic [ROW_W-1:0]     i_pos;
	logic [IW_W-1:0]      j_pos;
	logic [IH_W-1:0]      ch;
	logic [IW_W-1:0]      cw;
	logic [ROW_W-1:0]     ph;
	logic [COL_W-1:0]     pw;
	logic [ROW_W-2:0]     pi;
	logic [COL_W-1:0]     pj;
	meta_t                meta_d;

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	meta_t                meta_s1, meta_s2, meta_s3, meta_s4, meta_s5;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic [SLOT_W-1:0]    slot_s1;
	logic [IW_W-1:0]      c_s1;

	logic [LW-1:0]        line_rd;
	logic [LW-1:0]        line_wd;
	logic signed [SAMPLE_W-1:0] column [KSIZE];
	logic signed [SAMPLE_W-1:0] window_q [TAPS];
	logic signed [SAMPLE_W-1:0] weight_q [TAPS];
	logic signed [PROD_W-1:0]   prod_s3 [TAPS];
	logic signed [PART_W-1:0]   part_d [KSIZE];
	logic signed [PART_W-1:0]   part_s4 [KSIZE];
	logic signed [SUM_W-1:0]    sum_d;
	logic signed [SUM_W-1:0]    sum_s5;

	// The pipeline never stalls, so room is kept in the queue for every
	// request that may still be on its way through the stages.
	assign item_stall = q_count >= QCNT_W'(QDEPTH - PIPE_STAGES);
	assign accept     = item_valid && !item_stall;

	always_comb begin
		if (cfg.image_width < IW_W'(MIN_SIZE)) begin
			w = IW_W'(MIN_SIZE);
		end else if (32'(cfg.image_width) > MAX_WIDTH) begin
			w = IW_W'(MAX_WIDTH);
		end else begin
			w = cfg.image_width;
		end
		if (cfg.image_height < IH_W'(MIN_SIZE)) begin
			h = IH_W'(MIN_SIZE);
		end else if (cfg.image_height > IH_W'(MAX_HEIGHT)) begin
			h = IH_W'(MAX_HEIGHT);
		end else begin
			h = cfg.image_height;
		end
	end

	always_comb begin
		c_cur = col_q;
		r_pre = {1'b0, row_q};
		if (col_q >= w) begin
			c_cur = '0;
			r_pre = {1'b0, row_q} + IH_W'(1);
		end
		if (r_pre >= h) begin
			r_pre = '0;
		end
		r_cur  = r_pre[ROW_W-1:0];
		c_nx   = c_cur + IW_W'(1);
		r_nx   = r_cur;
		r_wide = {1'b0, r_cur} + IH_W'(1);
		if (c_nx >= w) begin
			c_nx = '0;
			r_nx = (r_wide >= h) ? '0 : r_wide[ROW_W-1:0];
		end
	end

	always_comb begin
		i_pos = r_cur - ROW_W'(KSIZE - 1);
		j_pos = c_cur - IW_W'(KSIZE - 1);
		ch    = h - IH_W'(KSIZE - 1);
		cw    = w - IW_W'(KSIZE - 1);
		ph    = ch[IH_W-1:1];
		pw    = cw[IW_W-1:1];
		pi    = i_pos[ROW_W-1:1];
		pj    = j_pos[IW_W-1:1];
		meta_d.pixel = (action == ACT_PIXEL);
		meta_d.push  = 1'b0;
		meta_d.op    = OP_DIRECT;
		meta_d.row   = i_pos;
		meta_d.col   = j_pos[COL_W-1:0];
		meta_d.done  = 1'b0;
		if (meta_d.pixel && r_cur >= ROW_W'(KSIZE - 1) && c_cur >= IW_W'(KSIZE - 1)) begin
			if (!cfg.pool_enable) begin
				meta_d.push = 1'b1;
				meta_d.done = ({1'b0, i_pos} == ch - IH_W'(1)) && (j_pos == cw - IW_W'(1));
			end else if ({1'b0, pi} < ph && pj < pw) begin
				meta_d.push = 1'b1;
				meta_d.row  = {1'b0, pi};
				meta_d.col  = pj;
				meta_d.done = ({1'b0, pi} == ph - ROW_W'(1)) && (pj == pw - COL_W'(1));
				if (!i_pos[0] && !j_pos[0]) begin
					meta_d.op = OP_POOL_INIT;
				end else if (i_pos[0] && j_pos[0]) begin
					meta_d.op = OP_POOL_EMIT;
				end else begin
					meta_d.op = OP_POOL_MAX;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept && meta_d.pixel) begin
			col_q <= c_nx;
			row_q <= r_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		meta_s1   <= meta_d;
		sample_s1 <= sample_value;
		slot_s1   <= weight_slot;
		c_s1      <= c_cur;
		meta_s2   <= meta_s1;
		meta_s3   <= meta_s2;
		meta_s4   <= meta_s3;
		meta_s5   <= meta_s4;
	end

	always_comb begin
		for (int k = 0; k < KSIZE - 1; k++) begin
			column[k] = line_rd[k*SAMPLE_W +: SAMPLE_W];
		end
		column[KSIZE-1] = sample_s1;
		for (int k = 0; k < KSIZE - 1; k++) begin
			line_wd[k*SAMPLE_W +: SAMPLE_W] = column[k+1];
		end
	end

	c5bm_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (v_s1 && meta_s1.pixel),
		.waddr (AW'(c_s1)),
		.wdata (line_wd),
		.re    (accept && meta_d.pixel),
		.raddr (AW'(c_cur)),
		.rdata (line_rd)
	);

	always_ff @(posedge clk) begin
		if (v_s1 && meta_s1.pixel) begin
			for (int k = 0; k < KSIZE; k++) begin
				for (int l = 0; l < KSIZE - 1; l++) begin
					window_q[k*KSIZE+l] <= window_q[k*KSIZE+l+1];
				end
				window_q[k*KSIZE+KSIZE-1] <= column[k];
			end
		end
		if (v_s1 && !meta_s1.pixel && slot_s1 < SLOT_W'(TAPS)) begin
			weight_q[slot_s1] <= sample_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < TAPS; k++) begin
			prod_s3[k] <= window_q[k] * weight_q[k];
		end
	end

	// A negative product drops by one below its truncated quotient, which is the
	// floor except when the fraction bits are all zero.
	always_comb begin
		logic signed [SC_W-1:0] sc;
		sc = '0;
		for (int g = 0; g < KSIZE; g++) begin
			part_d[g] = '0;
			for (int l = 0; l < KSIZE; l++) begin
				sc = prod_s3[g*KSIZE+l][PROD_W-1:FRAC_BITS]
					- SC_W'(prod_s3[g*KSIZE+l][PROD_W-1]
					&& prod_s3[g*KSIZE+l][FRAC_BITS-1:0] == '0);
				part_d[g] = part_d[g] + PART_W'(sc);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < KSIZE; g++) begin
			part_s4[g] <= part_d[g];
		end
	end

	always_comb begin
		sum_d = SUM_W'($signed(cfg.bias_value));
		for (int g = 0; g < KSIZE; g++) begin
			sum_d = sum_d + SUM_W'(part_s4[g]);
		end
	end

	always_ff @(posedge clk) begin
		sum_s5 <= sum_d;
	end

	assign push           = v_s5 && meta_s5.push;
	assign push_job.value = sum_s5[SUM_W-1] ? '0 : sum_s5[VAL_W-1:0];
	assign push_job.op    = meta_s5.op;
	assign push_job.row   = meta_s5.row;
	assign push_job.col   = meta_s5.col;
	assign push_job.done  = meta_s5.done;

endmodule

>>> rtl/c5bm_queue.sv
`timescale 1ns / 1ps
module c5bm_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  c5bm_pkg::job_t              push_job,
	input  logic                        pop,
	output c5bm_pkg::job_t              pop_job,
	output logic                        not_empty,
	output logic [c5bm_pkg::QCNT_W-1:0] count
);
	import c5bm_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;

	assign pop_job   = mem_q[rptr_q];
	assign not_empty = count_q != '0;
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_job;
		end
	end

endmodule

>>> rtl/c5bm_back.sv
`timescale 1ns / 1ps
module c5bm_back #(
	parameter int MAX_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  c5bm_pkg::job_t             job,
	input  logic                       not_empty,
	output logic                       pop,
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic [c5bm_pkg::VAL_W-1:0] feature_value,
	output logic [c5bm_pkg::ROW_W-1:0] out_row,
	output logic [c5bm_pkg::COL_W-1:0] out_col,
	output logic                       map_done
);
	import c5bm_pkg::*;

	localparam int PDEPTH = MAX_WIDTH / POOL_SIZE;
	localparam int PAW    = $clog2(PDEPTH);

	logic [VAL_W-1:0] pool_q [PDEPTH];
	logic [PAW-1:0]   idx;
	logic [VAL_W-1:0] old_val;
	logic [VAL_W-1:0] max_val;
	logic [VAL_W-1:0] emit_val;
	logic [VAL_W-1:0] pool_wd;
	logic             pool_we;
	logic             emits;
	logic             out_free;
	logic             res_valid_q;

	assign idx      = PAW'(job.col);
	assign old_val  = pool_q[idx];
	assign max_val  = (job.value > old_val) ? job.value : old_val;
	assign out_free = !res_valid_q || !res_stall;
	assign pop      = not_empty && (out_free || !emits);

	always_comb begin
		emits    = 1'b0;
		pool_we  = 1'b0;
		pool_wd  = max_val;
		emit_val = max_val;
		case (job.op)
			OP_DIRECT: begin
				emits    = 1'b1;
				emit_val = job.value;
			end
			OP_POOL_INIT: begin
				pool_we = 1'b1;
				pool_wd = job.value;
			end
			OP_POOL_MAX: begin
				pool_we = 1'b1;
			end
			OP_POOL_EMIT: begin
				pool_we = 1'b1;
				emits   = 1'b1;
			end
			default: begin
				emits   = 1'b0;
				pool_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop && pool_we) begin
			pool_q[idx] <= pool_wd;
		end
		if (pop && emits) begin
			feature_value <= emit_val;
			out_row       <= job.row;
			out_col       <= job.col;
			map_done      <= job.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop && emits) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;

endmodule

>>> rtl/conv5x5_bias_relu_maxpool_unit.sv
`timescale 1ns / 1ps
// A request is taken every cycle unless item_stall is high; the pipeline is fed
// straight from the input port. A result passes five stages of line store read,
// window shift, multiply, partial sums and bias, then the queue and the output register.
// The eight-entry queue absorbs output stalls, and input stalls while three or more wait.
// Reset clears the counters, queue and valid flags; weights and line store hold no reset.
module conv5x5_bias_relu_maxpool_unit #(
	parameter int MAX_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [c5bm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [c5bm_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic                                  action,
	input  logic [c5bm_pkg::SLOT_W-1:0]           weight_slot,
	input  logic signed [c5bm_pkg::SAMPLE_W-1:0]  sample_value,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output logic [c5bm_pkg::VAL_W-1:0]            feature_value,
	output logic [c5bm_pkg::ROW_W-1:0]            out_row,
	output logic [c5bm_pkg::COL_W-1:0]            out_col,
	output logic                                  map_done
);
	import c5bm_pkg::*;

	localparam logic [IW_W-1:0]     RST_WIDTH  = IW_W'(28);
	localparam logic [IH_W-1:0]     RST_HEIGHT = IH_W'(28);
	localparam logic [SAMPLE_W-1:0] RST_BIAS   = '0;
	localparam logic                RST_POOL   = 1'b1;

	cfg_t              cfg_q;
	logic              push;
	job_t              push_job;
	logic              pop;
	job_t              pop_job;
	logic              not_empty;
	logic [QCNT_W-1:0] q_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= RST_WIDTH;
			cfg_q.image_height <= RST_HEIGHT;
			cfg_q.bias_value   <= RST_BIAS;
			cfg_q.pool_enable  <= RST_POOL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data[IW_W-1:0];
				CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[IH_W-1:0];
				CFG_BIAS_VALUE:   cfg_q.bias_value   <= cfg_data[SAMPLE_W-1:0];
				CFG_POOL_ENABLE:  cfg_q.pool_enable  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	c5bm_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.action       (action),
		.weight_slot  (weight_slot),
		.sample_value (sample_value),
		.q_count      (q_count),
		.push         (push),
		.push_job     (push_job)
	);

	c5bm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.pop_job   (pop_job),
		.not_empty (not_empty),
		.count     (q_count)
	);

	c5bm_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job           (pop_job),
		.not_empty     (not_empty),
		.pop           (pop),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.feature_value (feature_value),
		.out_row       (out_row),
		.out_col       (out_col),
		.map_done      (map_done)
	);

endmodule

>>> test/conv_feature_checker.sv
`timescale 1ns / 1ps
module conv_feature_checker #(
	parameter int MAX_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic [c5bm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [c5bm_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  item_valid,
	input  logic                                  item_stall,
	input  logic                                  action,
	input  logic [c5bm_pkg::SLOT_W-1:0]           weight_slot,
	input  logic signed [c5bm_pkg::SAMPLE_W-1:0]  sample_value,
	input  logic                                  res_valid,
	input  logic                                  res_stall,
	input  logic [c5bm_pkg::VAL_W-1:0]            feature_value,
	input  logic [c5bm_pkg::ROW_W-1:0]            out_row,
	input  logic [c5bm_pkg::COL_W-1:0]            out_col,
	input  logic                                  map_done,
	output int                                    errors,
	output int                                    outstanding
);
	import c5bm_pkg::*;

	localparam int POOL_SLOTS = MAX_WIDTH / POOL_SIZE;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             done;
	} feature_t;

	feature_t pending_features[$];

	logic signed [SAMPLE_W-1:0] taps [TAPS];
	logic signed [SAMPLE_W-1:0] row_lines [KSIZE-1][MAX_WIDTH];
	logic signed [SAMPLE_W-1:0] window [TAPS];
	logic [VAL_W-1:0]           pool_max [POOL_SLOTS];
	int                         raster_row;
	int                         raster_col;

	logic [IW_W-1:0]            width_q;
	logic [IH_W-1:0]            height_q;
	logic signed [SAMPLE_W-1:0] bias_q;
	logic                       pool_q;

	int                         err_cnt;

	function automatic int clamp_size(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic logic [VAL_W-1:0] window_sum();
		int acc;
		int prod;
		acc = 0;
		for (int k = 0; k < TAPS; k++) begin
			prod = int'(window[k]) * int'(taps[k]);
			if (prod >= 0) begin
				acc += prod / (1 << FRAC_BITS);
			end else begin
				acc += prod / (1 << FRAC_BITS) - 1;
			end
		end
		acc += int'(bias_q);
		if (acc < 0) begin
			acc = 0;
		end
		return acc[VAL_W-1:0];
	endfunction

	function automatic bit predict_feature(input logic signed [SAMPLE_W-1:0] pix,
			output feature_t f);
		logic signed [SAMPLE_W-1:0] column [KSIZE];
		logic [VAL_W-1:0] v;
		int w, h, r, c, i, j, ch, cw, ph, pw, pi, pj, slot;
		bit hit;
		w = clamp_size(int'(width_q), MIN_SIZE, MAX_WIDTH);
		h = clamp_size(int'(height_q), MIN_SIZE, MAX_HEIGHT);
		hit = 1'b0;
		f = '0;
		if (raster_col >= w) begin
			raster_col = 0;
			raster_row++;
		end
		if (raster_row >= h) begin
			raster_row = 0;
		end
		r = raster_row;
		c = raster_col;

		for (int k = 0; k < KSIZE - 1; k++) begin
			column[k] = row_lines[k][c];
		end
		column[KSIZE-1] = pix;
		for (int k = 0; k < KSIZE - 1; k++) begin
			row_lines[k][c] = column[k+1];
		end
		for (int k = 0; k < KSIZE; k++) begin
			for (int l = 0; l < KSIZE - 1; l++) begin
				window[k*KSIZE+l] = window[k*KSIZE+l+1];
			end
			window[k*KSIZE+KSIZE-1] = column[k];
		end

		if (r >= KSIZE - 1 && c >= KSIZE - 1) begin
			i = r - (KSIZE - 1);
			j = c - (KSIZE - 1);
			ch = h - (KSIZE - 1);
			cw = w - (KSIZE - 1);
			v = window_sum();
			if (!pool_q) begin
				hit = 1'b1;
				f.value = v;
				f.row = ROW_W'(i);
				f.col = COL_W'(j);
				f.done = (i == ch - 1 && j == cw - 1);
			end else begin
				ph = ch / POOL_SIZE;
				pw = cw / POOL_SIZE;
				pi = i / POOL_SIZE;
				pj = j / POOL_SIZE;
				if (pi < ph && pj < pw) begin
					slot = pj % POOL_SLOTS;
					if (i % POOL_SIZE == 0 && j % POOL_SIZE == 0) begin
						pool_max[slot] = v;
					end else if (v > pool_max[slot]) begin
						pool_max[slot] = v;
					end
					if (i % POOL_SIZE == POOL_SIZE - 1 && j % POOL_SIZE == POOL_SIZE - 1) begin
						hit = 1'b1;
						f.value = pool_max[slot];
						f.row = ROW_W'(pi);
						f.col = COL_W'(pj);
						f.done = (pi == ph - 1 && pj == pw - 1);
					end
				end
			end
		end

		raster_col = c + 1;
		if (raster_col >= w) begin
			raster_col = 0;
			raster_row = r + 1;
			if (raster_row >= h) begin
				raster_row = 0;
			end
		end
		return hit;
	endfunction

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		feature_t want_f;
		feature_t next_f;
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				taps[k] = '0;
				window[k] = '0;
			end
			for (int k = 0; k < KSIZE - 1; k++) begin
				for (int m = 0; m < MAX_WIDTH; m++) begin
					row_lines[k][m] = '0;
				end
			end
			for (int k = 0; k < POOL_SLOTS; k++) begin
				pool_max[k] = '0;
			end
			raster_row = 0;
			raster_col = 0;
			width_q = IW_W'(28);
			height_q = IH_W'(28);
			bias_q = '0;
			pool_q = 1'b1;
			pending_features.delete();
			err_cnt = 0;
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (pending_features.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected result, expected none, got value %0d row %0d col %0d done %0d",
						$time, feature_value, out_row, out_col, map_done);
				end else begin
					want_f = pending_features.pop_front();
					check_field("feature_value", feature_value, want_f.value);
					check_field("out_row", out_row, want_f.row);
					check_field("out_col", out_col, want_f.col);
					check_field("map_done", map_done, want_f.done);
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH:  width_q = cfg_data[IW_W-1:0];
					CFG_IMAGE_HEIGHT: height_q = cfg_data[IH_W-1:0];
					CFG_BIAS_VALUE:   bias_q = cfg_data;
					CFG_POOL_ENABLE:  pool_q = cfg_data[0];
					default: ;
				endcase
			end

			if (item_valid && !item_stall) begin
				if (action == ACT_PIXEL) begin
					if (predict_feature(sample_value, next_f)) begin
						pending_features.push_back(next_f);
					end
				end else if (weight_slot < TAPS) begin
					taps[weight_slot] = sample_value;
				end
			end

			errors <= err_cnt;
			outstanding <= pending_features.size();
		end
	end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import c5bm_pkg::*;

	localparam int   IMG_MAX_W     = 32;
	localparam int   RANDOM_PIXELS = 40;
	localparam int   DRAIN_CYCLES  = 40;
	localparam logic ACT_WEIGHT    = ~ACT_PIXEL;

	typedef enum int {
		SRC_FULL,
		SRC_SMALL,
		SRC_EXTREME,
		SRC_MOST_NEG,
		SRC_MOST_POS
	} sample_mode_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;
	logic                       item_valid;
	logic                       item_stall;
	logic                       action;
	logic [SLOT_W-1:0]          weight_slot;
	logic signed [SAMPLE_W-1:0] sample_value;
	logic                       res_valid;
	logic                       res_stall;
	logic [VAL_W-1:0]           feature_value;
	logic [ROW_W-1:0]           out_row;
	logic [COL_W-1:0]           out_col;
	logic                       map_done;

	int                         errors;
	int                         outstanding;
	int                         sent;
	bit                         src_steady;

	conv5x5_bias_relu_maxpool_unit #(
		.MAX_WIDTH(IMG_MAX_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.action(action),
		.weight_slot(weight_slot),
		.sample_value(sample_value),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.feature_value(feature_value),
		.out_row(out_row),
		.out_col(out_col),
		.map_done(map_done)
	);

	conv_feature_checker #(
		.MAX_WIDTH(IMG_MAX_W)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.action(action),
		.weight_slot(weight_slot),
		.sample_value(sample_value),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.feature_value(feature_value),
		.out_row(out_row),
		.out_col(out_col),
		.map_done(map_done),
		.errors(errors),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("conv5x5_bias_relu_maxpool_unit test failed");
		$finish;
	end

	initial begin : result_sink
		int  gap;
		int  served;
		bit  sink_steady;
		served = 0;
		sink_steady = 1'b0;
		forever begin
			if (served % 64 == 0) begin
				sink_steady = ($urandom_range(0, 3) == 0);
			end
			gap = sink_steady ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				res_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
			served++;
		end
	end

	function automatic int clamp_size(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic logic [SAMPLE_W-1:0] draw_sample(input sample_mode_t mode);
		logic [SAMPLE_W-1:0] corner [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
		logic [SAMPLE_W-1:0] s;
		case (mode)
			SRC_FULL:     s = SAMPLE_W'($urandom);
			SRC_SMALL:    s = SAMPLE_W'($urandom_range(0, 1023) - 512);
			SRC_MOST_NEG: s = 16'h8000;
			SRC_MOST_POS: s = 16'h7FFF;
			default:      s = corner[$urandom_range(0, 4)];
		endcase
		return s;
	endfunction

	task automatic send_item(input logic act, input logic [SLOT_W-1:0] slot,
			input logic [SAMPLE_W-1:0] value);
		int gap;
		if (sent % 64 == 0) begin
			src_steady = ($urandom_range(0, 3) == 0);
		end
		sent++;
		gap = src_steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		action <= act;
		weight_slot <= slot;
		sample_value <= value;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic configure(input int w_wr, input int h_wr, input int bias, input logic pool);
		logic [CFG_DATA_W-1:0] pad;
		wait_idle();
		pad = ($urandom_range(0, 1) == 1) ? CFG_DATA_W'($urandom) : '0;
		write_reg(CFG_IMAGE_WIDTH, {pad[CFG_DATA_W-1:IW_W], IW_W'(w_wr)});
		write_reg(CFG_IMAGE_HEIGHT, {pad[CFG_DATA_W-1:IH_W], IH_W'(h_wr)});
		write_reg(CFG_BIAS_VALUE, CFG_DATA_W'(bias));
		write_reg(CFG_POOL_ENABLE, {pad[CFG_DATA_W-1:1], pool});
		cfg_valid <= 1'b0;
	endtask

	task automatic load_filter(input sample_mode_t mode);
		for (int s = 0; s < TAPS; s++) begin
			send_item(ACT_WEIGHT, SLOT_W'(s), draw_sample(mode));
		end
	endtask

	task automatic run_images(input int w, input int h, input sample_mode_t mode,
			input int images, input bit noise);
		for (int n = 0; n < images * w * h; n++) begin
			if (noise && $urandom_range(0, 24) == 0) begin
				send_item(ACT_WEIGHT, SLOT_W'($urandom_range(0, 31)), draw_sample(SRC_FULL));
			end
			send_item(ACT_PIXEL, SLOT_W'($urandom), draw_sample(mode));
		end
	endtask

	initial begin : stimulus
		int           w_wr;
		int           h_wr;
		int           w_eff;
		int           h_eff;
		int           images;
		int           bias;
		int           random_px;
		sample_mode_t mode;

		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data <= '0;
		item_valid <= 1'b0;
		action <= ACT_WEIGHT;
		weight_slot <= '0;
		sample_value <= '0;
		sent = 0;
		src_steady = 1'b0;
		random_px = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Largest magnitudes and corner values, out-of-range slots and sizes that saturate.
		load_filter(SRC_MOST_NEG);
		send_item(ACT_WEIGHT, SLOT_W'(25), 16'h7FFF);
		send_item(ACT_WEIGHT, SLOT_W'(31), 16'h7FFF);
		configure(2, 3, 32767, 1'b0);
		run_images(6, 6, SRC_MOST_NEG, 1, 1'b0);
		configure(6, 6, -32768, 1'b1);
		run_images(6, 6, SRC_MOST_POS, 1, 1'b0);
		configure(7, 7, 0, 1'b1);
		run_images(7, 7, SRC_EXTREME, 1, 1'b0);

		while (random_px < RANDOM_PIXELS) begin
			if ($urandom_range(0, 3) != 0) begin
				load_filter(sample_mode_t'($urandom_range(0, 2)));
			end
			case ($urandom_range(0, 9))
				0:       w_wr = $urandom_range(0, 5);
				1:       w_wr = $urandom_range(32, 63);
				default: w_wr = $urandom_range(6, 12);
			endcase
			h_wr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : $urandom_range(6, 10);
			if ($urandom_range(0, 1) == 1) begin
				bias = int'($urandom_range(0, 65535)) - 32768;
			end else begin
				bias = int'($urandom_range(0, 2047)) - 1024;
			end
			case ($urandom_range(0, 3))
				0:       mode = SRC_SMALL;
				1:       mode = SRC_EXTREME;
				default: mode = SRC_FULL;
			endcase
			w_eff = clamp_size(w_wr, MIN_SIZE, IMG_MAX_W);
			h_eff = clamp_size(h_wr, MIN_SIZE, MAX_HEIGHT);
			images = $urandom_range(1, 2);
			configure(w_wr, h_wr, bias, 1'($urandom_range(0, 1)));
			run_images(w_eff, h_eff, mode, images, 1'b1);
			random_px += images * w_eff * h_eff;
		end

		load_filter(SRC_FULL);
		configure(63, 6, int'($urandom_range(0, 4095)) - 2048, 1'b0);
		run_images(IMG_MAX_W, 6, SRC_SMALL, 1, 1'b1);
		configure(IMG_MAX_W, 7, int'($urandom_range(0, 4095)) - 2048, 1'b1);
		run_images(IMG_MAX_W, 7, SRC_FULL, 1, 1'b1);
		configure(6, 2047, int'($urandom_range(0, 4095)) - 2048, 1'b0);
		run_images(6, 8, SRC_FULL, 1, 1'b1);

		wait_idle();
		if (errors == 0) begin
			$display("conv5x5_bias_relu_maxpool_unit test passed");
		end else begin
			$display("conv5x5_bias_relu_maxpool_unit test failed");
		end
		$finish;
	end

endmodule

>>> conv5x5_bias_relu_maxpool_unit.f
rtl/c5bm_pkg.sv
rtl/c5bm_ram.sv
rtl/c5bm_front.sv
rtl/c5bm_queue.sv
rtl/c5bm_back.sv
rtl/conv5x5_bias_relu_maxpool_unit.sv
test/conv_feature_checker.sv
test/tb_top.sv
